// File: rtl/dsi_pkg.sv
package dsi_pkg;

    localparam int DEF_LANES        = 8;
    localparam int DEF_MAX_SPAN_LEN = 512;
    localparam int MAX_RESULTS      = 64;
    localparam int DEPTH_LANES      = 8;
    localparam int QUEUE_DEPTH      = 2;

    localparam int ZI_W    = 32;
    localparam int COORD_W = 12;
    localparam int LEN_W   = 10;
    localparam int ROW_W   = 13;
    localparam int INDEX_W = 24;
    localparam int DEPTH_W = 16;
    localparam int COUNT_W = 4;
    localparam int CFG_IDX_W = 3;

    localparam logic [ROW_W-1:0] ROW_WIDTH_RESET = 13'd320;

    localparam logic [CFG_IDX_W-1:0] CFG_ZI_ORIGIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZI_STEP_X   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZI_STEP_Y   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_ROW_WIDTH = 3'd3;

    typedef struct packed {
        logic [ZI_W-1:0]    izi;
        logic [INDEX_W-1:0] index;
        logic [LEN_W-1:0]   len;
    } t_span;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic [INDEX_W-1:0]                    index;
        logic [DEPTH_LANES-1:0][DEPTH_W-1:0]   depth;
        logic [COUNT_W-1:0]                    lane_count;
        logic                                  last;
    } t_group;

endpackage

// File: rtl/dsi_front.sv
module dsi_front
    import dsi_pkg::*;
#(
    parameter int LANES        = DEF_LANES,
    parameter int MAX_SPAN_LEN = DEF_MAX_SPAN_LEN
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [COORD_W-1:0] i_span_x,
    input  logic [COORD_W-1:0] i_span_y,
    input  logic [LEN_W-1:0]   i_span_len,
    input  logic [ZI_W-1:0]    i_zi_origin,
    input  logic [ZI_W-1:0]    i_zi_step_x,
    input  logic [ZI_W-1:0]    i_zi_step_y,
    input  logic [ROW_W-1:0]   i_row_width,
    input  t_q_status          i_q_status,
    output logic               o_push,
    output t_span              o_span
);

    localparam int CAP_RAW = (MAX_SPAN_LEN < MAX_RESULTS * LANES) ?
                             MAX_SPAN_LEN : MAX_RESULTS * LANES;
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(CAP_RAW);

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_SUM, S_PUSH} t_state;

    t_state              r_state;
    logic [COORD_W-1:0]  r_x;
    logic [COORD_W-1:0]  r_y;
    logic [LEN_W-1:0]    r_len;
    logic [ZI_W-1:0]     r_prod_x;
    logic [ZI_W-1:0]     r_prod_y;
    logic [INDEX_W-1:0]  r_prod_i;
    logic [ZI_W-1:0]     r_izi;
    logic [INDEX_W-1:0]  r_index;
    logic [LEN_W-1:0]    n_len;

    always_comb begin
        n_len = (i_span_len > LEN_CAP) ? LEN_CAP : i_span_len;
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_push  = (r_state == S_PUSH) && !i_q_status.full;
    assign o_span  = '{izi: r_izi, index: r_index, len: r_len};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_x   <= i_span_x;
                        r_y   <= i_span_y;
                        r_len <= n_len;
                        if (n_len != '0) begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_prod_x <= ZI_W'(ZI_W'(r_x) * i_zi_step_x);
                    r_prod_y <= ZI_W'(ZI_W'(r_y) * i_zi_step_y);
                    r_prod_i <= INDEX_W'(25'(i_row_width) * 25'(r_y));
                    r_state  <= S_SUM;
                end
                S_SUM: begin
                    r_izi   <= ZI_W'(i_zi_origin + r_prod_y + r_prod_x);
                    r_index <= INDEX_W'(r_prod_i + INDEX_W'(r_x));
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (!i_q_status.full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/dsi_queue.sv
module dsi_queue
    import dsi_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_span     i_span,
    input  logic      i_pop,
    output t_span     o_span,
    output t_q_status o_status
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    t_span            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_span         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CNT_FULL);
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_span;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : PTR_W'(r_wr_ptr + 1'b1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : PTR_W'(r_rd_ptr + 1'b1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= CNT_W'(r_count + 1'b1);
                2'b01:   r_count <= CNT_W'(r_count - 1'b1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/dsi_back.sv
module dsi_back
    import dsi_pkg::*;
#(
    parameter int LANES = DEF_LANES
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [ZI_W-1:0] i_zi_step_x,
    input  t_q_status       i_q_status,
    input  t_span           i_span,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output t_group          o_group
);

    localparam logic [LEN_W-1:0]   LANES_LEN = LEN_W'(LANES);
    localparam logic [COUNT_W-1:0] LANES_CNT = COUNT_W'(LANES);
    localparam logic [INDEX_W-1:0] LANES_IDX = INDEX_W'(LANES);

    logic [ZI_W-1:0]    r_step_mul [LANES];
    logic [ZI_W-1:0]    r_step_grp;
    logic               r_busy;
    logic [ZI_W-1:0]    r_izi;
    logic [INDEX_W-1:0] r_index;
    logic [LEN_W-1:0]   r_remain;
    logic               r_valid;
    t_group             r_group;

    logic [COUNT_W-1:0]                  n_count;
    logic [DEPTH_LANES-1:0][DEPTH_W-1:0] n_depth;
    logic                                n_last;
    logic                                n_emit;

    // step multiples follow the config register; stable long before use
    for (genvar k = 0; k < LANES; k++) begin : g_mul
        always_ff @(posedge i_clk) begin
            r_step_mul[k] <= ZI_W'(i_zi_step_x * ZI_W'(k));
        end
    end

    always_ff @(posedge i_clk) begin
        r_step_grp <= ZI_W'(i_zi_step_x * ZI_W'(LANES));
    end

    always_comb begin
        n_last  = (r_remain <= LANES_LEN);
        n_count = n_last ? r_remain[COUNT_W-1:0] : LANES_CNT;
    end

    for (genvar j = 0; j < DEPTH_LANES; j++) begin : g_lane
        if (j < LANES) begin : g_on
            logic [ZI_W-1:0] w_sum;
            assign w_sum      = ZI_W'(r_izi + r_step_mul[j]);
            assign n_depth[j] = (COUNT_W'(j) < n_count) ? w_sum[ZI_W-1 -: DEPTH_W] : '0;
        end else begin : g_off
            assign n_depth[j] = '0;
        end
    end

    assign n_emit  = r_busy && (!r_valid || i_ready);
    assign o_pop   = !r_busy && !i_q_status.empty;
    assign o_valid = r_valid;
    assign o_group = r_group;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy   <= 1'b1;
                r_izi    <= i_span.izi;
                r_index  <= i_span.index;
                r_remain <= i_span.len;
            end else if (n_emit) begin
                r_busy   <= !n_last;
                r_izi    <= ZI_W'(r_izi + r_step_grp);
                r_index  <= INDEX_W'(r_index + LANES_IDX);
                r_remain <= LEN_W'(r_remain - LEN_W'(n_count));
            end
            if (n_emit) begin
                r_valid            <= 1'b1;
                r_group.index      <= r_index;
                r_group.depth      <= n_depth;
                r_group.lane_count <= n_count;
                r_group.last       <= n_last;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/depth_span_interpolator.sv
// Inverse depth span interpolator. Each request is a span (start column,
// row, length); the front end steps through capture, multiply, sum and
// queue write (held while the queue is full) to form the start inverse
// depth and buffer index, taking no new span until the write is done. A
// 2-entry queue feeds the back end, which loads a span and then emits one
// group of up to LANES depth words per cycle while the receiver is ready,
// loading no new span until its last group. Zero-length spans give no
// output; lengths are capped at min(MAX_SPAN_LEN, MAX_RESULTS*LANES) pixels.
module depth_span_interpolator
    import dsi_pkg::*;
#(
    parameter int LANES        = DEF_LANES,
    parameter int MAX_SPAN_LEN = DEF_MAX_SPAN_LEN
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ZI_W-1:0]           i_cfg_data,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [COORD_W-1:0]        i_span_x,
    input  logic [COORD_W-1:0]        i_span_y,
    input  logic [LEN_W-1:0]          i_span_len,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [INDEX_W-1:0]        o_buffer_index,
    output logic signed [DEPTH_W-1:0] o_depth_0,
    output logic signed [DEPTH_W-1:0] o_depth_1,
    output logic signed [DEPTH_W-1:0] o_depth_2,
    output logic signed [DEPTH_W-1:0] o_depth_3,
    output logic signed [DEPTH_W-1:0] o_depth_4,
    output logic signed [DEPTH_W-1:0] o_depth_5,
    output logic signed [DEPTH_W-1:0] o_depth_6,
    output logic signed [DEPTH_W-1:0] o_depth_7,
    output logic [COUNT_W-1:0]        o_lane_count,
    output logic                      o_last_group
);

    logic [ZI_W-1:0]  r_zi_origin;
    logic [ZI_W-1:0]  r_zi_step_x;
    logic [ZI_W-1:0]  r_zi_step_y;
    logic [ROW_W-1:0] r_row_width;

    t_q_status q_status;
    t_span     push_span;
    t_span     pop_span;
    logic      q_push;
    logic      q_pop;
    t_group    group;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zi_origin <= '0;
            r_zi_step_x <= '0;
            r_zi_step_y <= '0;
            r_row_width <= ROW_WIDTH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ZI_ORIGIN:   r_zi_origin <= i_cfg_data;
                CFG_ZI_STEP_X:   r_zi_step_x <= i_cfg_data;
                CFG_ZI_STEP_Y:   r_zi_step_y <= i_cfg_data;
                CFG_Z_ROW_WIDTH: r_row_width <= i_cfg_data[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    dsi_front #(
        .LANES        (LANES),
        .MAX_SPAN_LEN (MAX_SPAN_LEN)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_span_x    (i_span_x),
        .i_span_y    (i_span_y),
        .i_span_len  (i_span_len),
        .i_zi_origin (r_zi_origin),
        .i_zi_step_x (r_zi_step_x),
        .i_zi_step_y (r_zi_step_y),
        .i_row_width (r_row_width),
        .i_q_status  (q_status),
        .o_push      (q_push),
        .o_span      (push_span)
    );

    dsi_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_span   (push_span),
        .i_pop    (q_pop),
        .o_span   (pop_span),
        .o_status (q_status)
    );

    dsi_back #(
        .LANES (LANES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_zi_step_x (r_zi_step_x),
        .i_q_status  (q_status),
        .i_span      (pop_span),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_group     (group)
    );

    assign o_buffer_index = group.index;
    assign o_depth_0      = group.depth[0];
    assign o_depth_1      = group.depth[1];
    assign o_depth_2      = group.depth[2];
    assign o_depth_3      = group.depth[3];
    assign o_depth_4      = group.depth[4];
    assign o_depth_5      = group.depth[5];
    assign o_depth_6      = group.depth[6];
    assign o_depth_7      = group.depth[7];
    assign o_lane_count   = group.lane_count;
    assign o_last_group   = group.last;

    a_lane_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_lane_count != '0 && o_lane_count <= COUNT_W'(LANES)))
        else $error("lane count out of range");

    a_full_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_group) |-> (o_lane_count == COUNT_W'(LANES)))
        else $error("partial group not marked last");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_status.full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_status.empty)
        else $error("queue read while empty");

endmodule

// File: verif/depth_span_interpolator_test.sv
`timescale 1ns / 100ps

module depth_span_interpolator_test;
    import dsi_pkg::*;

    localparam int SETTLE_CYCLES   = 24;
    localparam int LONG_HOLD       = 400;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 36;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = 3'd4;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [LEN_W-1:0]   len;
    } t_span_req;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_index = CFG_ZI_ORIGIN;
    logic [ZI_W-1:0]           i_cfg_data = '0;
    logic                      i_valid = 1'b0;
    logic                      o_ready;
    logic [COORD_W-1:0]        i_span_x = '0;
    logic [COORD_W-1:0]        i_span_y = '0;
    logic [LEN_W-1:0]          i_span_len = '0;
    logic                      o_valid;
    logic                      i_ready = 1'b0;
    logic [INDEX_W-1:0]        o_buffer_index;
    logic signed [DEPTH_W-1:0] o_depth_0;
    logic signed [DEPTH_W-1:0] o_depth_1;
    logic signed [DEPTH_W-1:0] o_depth_2;
    logic signed [DEPTH_W-1:0] o_depth_3;
    logic signed [DEPTH_W-1:0] o_depth_4;
    logic signed [DEPTH_W-1:0] o_depth_5;
    logic signed [DEPTH_W-1:0] o_depth_6;
    logic signed [DEPTH_W-1:0] o_depth_7;
    logic [COUNT_W-1:0]        o_lane_count;
    logic                      o_last_group;

    depth_span_interpolator dut (.*);

    always #5 i_clk = ~i_clk;

    // shadow copy of the configuration registers
    logic [ZI_W-1:0]  cfg_origin    = '0;
    logic [ZI_W-1:0]  cfg_step_x    = '0;
    logic [ZI_W-1:0]  cfg_step_y    = '0;
    logic [ROW_W-1:0] cfg_row_width = ROW_WIDTH_RESET;

    t_span_req   pending_spans[$];
    t_group      expected_groups[$];
    t_span_req   active_span;
    int unsigned send_gap = 0;
    int unsigned recv_stall = 0;
    int unsigned hold_left = 0;
    int unsigned holds_requested = 0;
    int unsigned holds_served = 0;
    int unsigned fail_count = 0;
    bit          quiet_pacing = 1'b0;

    function automatic int unsigned draw_gap();
        return quiet_pacing ? 0 : $urandom_range(0, 15);
    endfunction

    function automatic void predict_span_groups(t_span_req s);
        logic [ZI_W-1:0]    zi;
        logic [INDEX_W-1:0] idx;
        int unsigned        len;
        int unsigned        done;
        int unsigned        n;
        t_group             g;
        len = 32'(s.len);
        if (len > DEF_MAX_SPAN_LEN) len = DEF_MAX_SPAN_LEN;
        if (len > MAX_RESULTS * DEF_LANES) len = MAX_RESULTS * DEF_LANES;
        zi = cfg_origin + ZI_W'(s.y) * cfg_step_y + ZI_W'(s.x) * cfg_step_x;
        idx = INDEX_W'(ZI_W'(cfg_row_width) * ZI_W'(s.y) + ZI_W'(s.x));
        done = 0;
        while (done < len) begin
            n = (len - done > DEF_LANES) ? DEF_LANES : len - done;
            g = '0;
            g.index = idx;
            for (int j = 0; j < DEPTH_LANES; j++) begin
                if (j < n) begin
                    g.depth[j] = zi[ZI_W-1 -: DEPTH_W];
                    zi = zi + cfg_step_x;
                end
            end
            done = done + n;
            g.lane_count = COUNT_W'(n);
            g.last = (done >= len);
            expected_groups.push_back(g);
            idx = idx + INDEX_W'(DEF_LANES);
        end
    endfunction

    function automatic void report_field(string what, logic [31:0] want, logic [31:0] got);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        fail_count++;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (i_valid && o_ready) predict_span_groups(active_span);
            if (!i_valid || o_ready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    i_valid <= 1'b0;
                end else if (pending_spans.size() != 0) begin
                    active_span = pending_spans.pop_front();
                    i_span_x <= active_span.x;
                    i_span_y <= active_span.y;
                    i_span_len <= active_span.len;
                    i_valid <= 1'b1;
                    send_gap <= draw_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver
    always @(posedge i_clk) begin
        t_group      got;
        t_group      want;
        int unsigned stall;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            recv_stall <= 0;
            hold_left <= 0;
            holds_served <= 0;
        end else begin
            if (o_valid && i_ready) begin
                got.index = o_buffer_index;
                got.depth[0] = o_depth_0;
                got.depth[1] = o_depth_1;
                got.depth[2] = o_depth_2;
                got.depth[3] = o_depth_3;
                got.depth[4] = o_depth_4;
                got.depth[5] = o_depth_5;
                got.depth[6] = o_depth_6;
                got.depth[7] = o_depth_7;
                got.lane_count = o_lane_count;
                got.last = o_last_group;
                if (expected_groups.size() == 0) begin
                    $display("%0t: unexpected group, expected none, actual index %0h",
                             $time, got.index);
                    fail_count++;
                end else begin
                    want = expected_groups.pop_front();
                    if (got.index !== want.index)
                        report_field("buffer_index", 32'(want.index), 32'(got.index));
                    for (int j = 0; j < DEPTH_LANES; j++) begin
                        if (got.depth[j] !== want.depth[j])
                            report_field($sformatf("depth_%0d", j),
                                         32'(want.depth[j]), 32'(got.depth[j]));
                    end
                    if (got.lane_count !== want.lane_count)
                        report_field("lane_count", 32'(want.lane_count),
                                     32'(got.lane_count));
                    if (got.last !== want.last)
                        report_field("last_group", 32'(want.last), 32'(got.last));
                end
            end
            if (holds_served != holds_requested) begin
                holds_served <= holds_requested;
                hold_left <= LONG_HOLD;
                i_ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                i_ready <= 1'b0;
            end else if (o_valid && i_ready) begin
                stall = draw_gap();
                recv_stall <= stall;
                i_ready <= (stall == 0);
            end else if (recv_stall != 0) begin
                recv_stall <= recv_stall - 1;
                i_ready <= (recv_stall == 1);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic push_span(input int x, input int y, input int len);
        t_span_req s;
        s.x = COORD_W'(x);
        s.y = COORD_W'(y);
        s.len = LEN_W'(len);
        pending_spans.push_back(s);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ZI_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        case (idx)
            CFG_ZI_ORIGIN:   cfg_origin = value;
            CFG_ZI_STEP_X:   cfg_step_x = value;
            CFG_ZI_STEP_Y:   cfg_step_y = value;
            CFG_Z_ROW_WIDTH: cfg_row_width = value[ROW_W-1:0];
            default: ;
        endcase
    endtask

    task automatic finish_writes();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // zero-length requests leave no trace, so settle before any register write
    task automatic wait_idle();
        while (pending_spans.size() != 0 || i_valid || expected_groups.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [ZI_W-1:0] random_step();
        logic [ZI_W-1:0] v;
        v = $urandom >> $urandom_range(0, 28);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    function automatic int pick_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5) return 0;
        if (r < 70) return $urandom_range(1, 24);
        if (r < 90) return $urandom_range(25, 200);
        if (r < 96) return $urandom_range(201, 512);
        return $urandom_range(513, 1023);
    endfunction

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        push_span(0, 0, 1);
        push_span(4095, 4095, 9);
        push_span(37, 5, 0);
        push_span(100, 7, 8);
        wait_idle();

        write_reg(CFG_ZI_ORIGIN, 32'h7FFF_FFFF);
        write_reg(CFG_ZI_STEP_X, 32'h8000_0000);
        write_reg(CFG_ZI_STEP_Y, 32'h7FFF_FFFF);
        write_reg(CFG_Z_ROW_WIDTH, 32'd4096);
        finish_writes();
        push_span(0, 0, 512);
        push_span(4095, 4095, 1);
        push_span(4095, 0, 8);
        push_span(0, 4095, 7);
        push_span(1, 1, 16);
        push_span(2047, 2048, 17);
        push_span(4095, 4095, 1023);
        push_span(5, 5, 0);
        push_span(9, 9, 513);
        push_span(3000, 123, 64);
        wait_idle();

        write_reg(CFG_ZI_ORIGIN, 32'h8000_0000);
        write_reg(CFG_ZI_STEP_X, 32'h7FFF_FFFF);
        write_reg(CFG_ZI_STEP_Y, 32'hFFFF_FFFF);
        write_reg(CFG_Z_ROW_WIDTH, 32'd1);
        finish_writes();
        push_span(0, 0, 1);
        push_span(4095, 4095, 512);
        push_span(1, 0, 9);
        push_span(0, 1, 15);
        push_span(4095, 1, 2);
        push_span(100, 200, 0);
        push_span(7, 4095, 24);
        push_span(2048, 2047, 3);
        push_span(4095, 4095, 1023);
        push_span(0, 0, 8);
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            quiet_pacing = (p == 5 || p == 6);
            write_reg(CFG_ZI_ORIGIN, (p == 0) ? 32'h8000_0000 :
                                     (p == 1) ? 32'h7FFF_FFFF : ZI_W'($urandom));
            write_reg(CFG_ZI_STEP_X, random_step());
            write_reg(CFG_ZI_STEP_Y, random_step());
            case (p)
                2:       write_reg(CFG_Z_ROW_WIDTH, 32'd0);
                3:       write_reg(CFG_Z_ROW_WIDTH, 32'hFFFF_FFFF);
                4:       write_reg(CFG_Z_ROW_WIDTH, 32'd4096);
                7:       write_reg(CFG_Z_ROW_WIDTH, ZI_W'($urandom));
                default: write_reg(CFG_Z_ROW_WIDTH, ZI_W'($urandom_range(1, 4096)));
            endcase
            // writes to unmapped indexes must leave the registers alone
            write_reg(CFG_FIRST_UNUSED + CFG_IDX_W'($urandom_range(0, 3)), ZI_W'($urandom));
            finish_writes();
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
                push_span($urandom_range(0, 4095), $urandom_range(0, 4095), pick_len());
            if (p == 6) holds_requested++;
            wait_idle();
        end

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: sim.f
rtl/dsi_pkg.sv
rtl/dsi_front.sv
rtl/dsi_queue.sv
rtl/dsi_back.sv
rtl/depth_span_interpolator.sv
verif/depth_span_interpolator_test.sv
